// File: src/sra_pkg.sv
// shared types and constants for the staging region allocator
package sra_pkg;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_COMMIT = 2'd1;
   localparam logic [1:0] OP_RETIRE = 2'd2;

   localparam logic CSR_BUFFER_SIZE = 1'b0;
   localparam logic CSR_ALIGN_LOG2  = 1'b1;

   localparam logic [31:0] BUFFER_SIZE_RESET = 32'd2097152;
   localparam logic [3:0]  ALIGN_LOG2_RESET  = 4'd4;

   // datapath operations issued by the controller
   localparam logic [3:0] DP_NOP      = 4'd0;
   localparam logic [3:0] DP_INIT     = 4'd1;
   localparam logic [3:0] DP_LOAD     = 4'd2;
   localparam logic [3:0] DP_MERGE    = 4'd3;
   localparam logic [3:0] DP_MFIN     = 4'd4;
   localparam logic [3:0] DP_SEARCH   = 4'd5;
   localparam logic [3:0] DP_ERASE    = 4'd6;
   localparam logic [3:0] DP_INSPOS   = 4'd7;
   localparam logic [3:0] DP_SHIFT    = 4'd8;
   localparam logic [3:0] DP_RETIRE   = 4'd9;
   localparam logic [3:0] DP_CLEAR    = 4'd10;
   localparam logic [3:0] DP_PICK     = 4'd11;
   localparam logic [3:0] DP_FULL     = 4'd12;

   typedef struct packed {
      logic [3:0] op;
   } sra_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pos_done;
      logic shift_done;
      logic found_fit;
      logic have_best;
      logic need_insert;
      logic table_full;
   } sra_status_type;

endpackage

// File: src/sra_if.sv
// valid/ready channel carrying request or response words
interface sra_req_if;
   logic valid;
   logic ready;
   logic [1:0] opcode;
   logic [31:0] req_size;
   logic [31:0] region_offset;
   logic [15:0] tag;
   modport source (output valid, opcode, req_size, region_offset, tag, input ready);
   modport sink   (input valid, opcode, req_size, region_offset, tag, output ready);
endinterface

interface sra_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] grant_offset;
   logic [31:0] grant_size;
   logic waited;
   logic status;
   modport source (output valid, grant_offset, grant_size, waited, status, input ready);
   modport sink   (input valid, grant_offset, grant_size, waited, status, output ready);
endinterface

// File: src/sra_datapath.sv
// region table and walking pointers for the allocator
module sra_datapath import sra_pkg::*; #(
   parameter int MAX_REGIONS = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  sra_cmd_type    cmd,
   input  logic [1:0]     in_op,
   input  logic [31:0]    in_size,
   input  logic [31:0]    in_off,
   input  logic [15:0]    in_tag,
   input  logic [31:0]    buffer_size,
   input  logic [3:0]     align_log2,
   output sra_status_type stat,
   output logic [31:0]    grant_offset,
   output logic [31:0]    grant_size,
   output logic           waited,
   output logic           status
);
   localparam int IW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_REGIONS);

   logic [31:0]       st_ff [MAX_REGIONS];
   logic [31:0]       ln_ff [MAX_REGIONS];
   logic [TAG_BITS-1:0] tg_ff [MAX_REGIONS];
   logic [MAX_REGIONS-1:0] rdy_ff;
   logic [CW-1:0]     cnt_ff;
   logic [CW-1:0]     r_ff, w_ff, pos_ff;
   logic [32:0]       aligned_ff;
   logic [32:0]       rem_ff;
   logic [31:0]       remoff_ff;
   logic [31:0]       ins_st_ff, ins_ln_ff;
   logic [TAG_BITS-1:0] ins_tg_ff;
   logic              ins_rdy_ff;
   logic              fit_ff, best_v_ff;
   logic [IW-1:0]     best_ff;
   logic [31:0]       go_ff, gs_ff;
   logic              wt_ff, stt_ff;
   logic              pos_done_ff;

   logic [IW-1:0] ri, wi, pi, ri1;
   logic [32:0]   amask, endw, sumw;
   logic [TAG_BITS-1:0] tg_in;

   assign ri   = r_ff[IW-1:0];
   assign wi   = w_ff[IW-1:0];
   assign pi   = pos_ff[IW-1:0];
   assign ri1  = IW'(r_ff + CW'(1));
   assign amask = (33'd1 << align_log2) - 33'd1;
   assign endw = {1'b0, st_ff[wi]} + {1'b0, ln_ff[wi]};
   assign sumw = {1'b0, ln_ff[wi]} + {1'b0, ln_ff[ri]};
   assign tg_in = TAG_BITS'(in_tag);

   // status to the controller
   always_comb begin
      stat.scan_done   = (r_ff >= cnt_ff);
      stat.pos_done    = pos_done_ff;
      stat.shift_done  = (r_ff <= pos_ff);
      stat.found_fit   = fit_ff;
      stat.have_best   = best_v_ff;
      stat.need_insert = (rem_ff != 33'd0);
      stat.table_full  = (cnt_ff >= MAXC);
   end

   assign grant_offset = go_ff;
   assign grant_size   = gs_ff;
   assign waited       = wt_ff;
   assign status       = stt_ff;

   // table operations, one entry step per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CW'(1);
         rdy_ff <= '1;
         st_ff[0] <= '0;
         ln_ff[0] <= BUFFER_SIZE_RESET;
         tg_ff[0] <= '0;
         r_ff <= '0;
         pos_done_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            DP_INIT: begin
               cnt_ff <= CW'(1);
               rdy_ff <= '1;
               st_ff[0] <= '0;
               ln_ff[0] <= buffer_size;
               tg_ff[0] <= '0;
            end
            DP_LOAD: begin
               aligned_ff <= ({1'b0, in_size} + amask) & ~amask;
               // allocate starts merging at entry 1, the others walk from entry 0
               r_ff <= (in_op == OP_ALLOC) ? CW'(1) : '0;
               w_ff <= '0;
               fit_ff <= 1'b0;
               best_v_ff <= 1'b0;
               rem_ff <= '0;
               go_ff <= '0; gs_ff <= '0; wt_ff <= 1'b0; stt_ff <= 1'b0;
               pos_ff <= '0;
               pos_done_ff <= 1'b0;
               if (in_op == OP_COMMIT) begin
                  ins_st_ff <= in_off; ins_ln_ff <= in_size;
                  ins_tg_ff <= tg_in; ins_rdy_ff <= 1'b0;
               end
            end
            DP_MERGE: begin
               if (rdy_ff[wi] && rdy_ff[ri] && endw == {1'b0, st_ff[ri]} && !sumw[32]) begin
                  ln_ff[wi] <= sumw[31:0];
                  tg_ff[wi] <= '0;
               end else begin
                  st_ff[IW'(w_ff + CW'(1))]  <= st_ff[ri];
                  ln_ff[IW'(w_ff + CW'(1))]  <= ln_ff[ri];
                  tg_ff[IW'(w_ff + CW'(1))]  <= tg_ff[ri];
                  rdy_ff[IW'(w_ff + CW'(1))] <= rdy_ff[ri];
                  w_ff <= w_ff + CW'(1);
               end
               r_ff <= r_ff + CW'(1);
            end
            DP_MFIN: begin
               if (cnt_ff > CW'(1)) cnt_ff <= w_ff + CW'(1);
               r_ff <= '0;
            end
            DP_SEARCH: begin
               // a fit stops the walk with the pointer left on the fitting entry
               if (rdy_ff[ri] && {1'b0, ln_ff[ri]} >= aligned_ff) begin
                  fit_ff <= 1'b1;
                  go_ff <= st_ff[ri];
                  gs_ff <= aligned_ff[31:0];
                  rem_ff <= {1'b0, ln_ff[ri]} - aligned_ff;
                  remoff_ff <= st_ff[ri] + aligned_ff[31:0];
               end else begin
                  if (rdy_ff[ri] && (!best_v_ff || ln_ff[ri] > ln_ff[best_ff])) begin
                     best_v_ff <= 1'b1;
                     best_ff <= ri;
                  end
                  r_ff <= r_ff + CW'(1);
               end
            end
            DP_PICK: begin
               // partial grant of the largest ready region
               go_ff <= st_ff[best_ff];
               gs_ff <= ln_ff[best_ff];
               fit_ff <= 1'b1;
               r_ff <= CW'(best_ff);
            end
            DP_ERASE: begin
               if (r_ff + CW'(1) < cnt_ff) begin
                  st_ff[ri] <= st_ff[ri1]; ln_ff[ri] <= ln_ff[ri1];
                  tg_ff[ri] <= tg_ff[ri1]; rdy_ff[ri] <= rdy_ff[ri1];
                  r_ff <= r_ff + CW'(1);
               end else begin
                  cnt_ff <= cnt_ff - CW'(1);
                  r_ff <= cnt_ff;
                  ins_st_ff <= remoff_ff; ins_ln_ff <= rem_ff[31:0];
                  ins_tg_ff <= '0; ins_rdy_ff <= 1'b1;
                  pos_ff <= '0;
               end
            end
            DP_INSPOS: begin
               if (pos_ff < cnt_ff && st_ff[pi] < ins_st_ff) pos_ff <= pos_ff + CW'(1);
               else begin
                  pos_done_ff <= 1'b1;
                  r_ff <= cnt_ff;
               end
            end
            DP_SHIFT: begin
               pos_done_ff <= 1'b0;
               if (r_ff > pos_ff) begin
                  st_ff[ri] <= st_ff[IW'(r_ff - CW'(1))];
                  ln_ff[ri] <= ln_ff[IW'(r_ff - CW'(1))];
                  tg_ff[ri] <= tg_ff[IW'(r_ff - CW'(1))];
                  rdy_ff[ri] <= rdy_ff[IW'(r_ff - CW'(1))];
                  r_ff <= r_ff - CW'(1);
               end else begin
                  st_ff[pi] <= ins_st_ff; ln_ff[pi] <= ins_ln_ff;
                  tg_ff[pi] <= ins_tg_ff; rdy_ff[pi] <= ins_rdy_ff;
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            DP_RETIRE: begin
               if (!rdy_ff[ri] && tg_ff[ri] == tg_in) begin
                  rdy_ff[ri] <= 1'b1;
                  tg_ff[ri] <= '0;
               end
               r_ff <= r_ff + CW'(1);
            end
            DP_CLEAR: begin
               // wait path: table restarts, remainder after the grant
               cnt_ff <= '0;
               wt_ff <= 1'b1;
               go_ff <= '0;
               if ({1'b0, buffer_size} > aligned_ff) begin
                  rem_ff <= {1'b0, buffer_size} - aligned_ff;
                  gs_ff <= aligned_ff[31:0];
                  ins_st_ff <= aligned_ff[31:0];
                  ins_ln_ff <= buffer_size - aligned_ff[31:0];
               end else begin
                  rem_ff <= '0;
                  gs_ff <= buffer_size;
               end
               ins_tg_ff <= '0; ins_rdy_ff <= 1'b1;
               pos_ff <= '0;
            end
            DP_FULL: begin
               // commit dropped on a full table
               stt_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end
endmodule

// File: src/sra_ctrl.sv
// sequencer stepping the datapath through each operation
module sra_ctrl import sra_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  logic [1:0]     in_op,
   input  logic           cfg_init,
   input  sra_status_type stat,
   output logic           in_ready,
   output logic           out_valid,
   input  logic           out_ready,
   output sra_cmd_type    cmd
);
   localparam logic [3:0] S_IDLE = 4'd0, S_MERGE = 4'd1, S_MFIN = 4'd2, S_SEARCH = 4'd3,
      S_ERASE = 4'd4, S_INSPOS = 4'd5, S_SHIFT = 4'd6, S_RETIRE = 4'd7, S_CLEAR = 4'd8,
      S_FULL = 4'd9, S_OUT = 4'd10, S_DEC = 4'd11, S_PICK = 4'd12;

   logic [3:0] state_ff, state_in;
   logic out_ff, out_in;

   // a pending table init takes the idle cycle, so no word is taken then
   assign in_ready  = (state_ff == S_IDLE) && !out_ff && !cfg_init;
   assign out_valid = out_ff;

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      out_in = out_ff && !out_ready;
      cmd.op = DP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (cfg_init) cmd.op = DP_INIT;
            else if (in_valid && in_ready) begin
               cmd.op = DP_LOAD;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            priority if (in_op == OP_ALLOC) state_in = S_MERGE;
            else if (in_op == OP_COMMIT) state_in = stat.table_full ? S_FULL : S_INSPOS;
            else if (in_op == OP_RETIRE) state_in = S_RETIRE;
            else state_in = S_OUT;
         end
         S_MERGE: begin
            if (stat.scan_done) state_in = S_MFIN;
            else cmd.op = DP_MERGE;
         end
         S_MFIN: begin cmd.op = DP_MFIN; state_in = S_SEARCH; end
         S_SEARCH: begin
            if (stat.found_fit) state_in = S_ERASE;
            else if (stat.scan_done) state_in = stat.have_best ? S_PICK : S_CLEAR;
            else cmd.op = DP_SEARCH;
         end
         S_PICK: begin cmd.op = DP_PICK; state_in = S_ERASE; end
         S_ERASE: begin
            if (stat.scan_done) state_in = stat.need_insert ? S_INSPOS : S_OUT;
            else cmd.op = DP_ERASE;
         end
         S_CLEAR: begin cmd.op = DP_CLEAR; state_in = S_ERASE; end
         S_INSPOS: begin
            cmd.op = DP_INSPOS;
            if (stat.pos_done) state_in = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.op = DP_SHIFT;
            if (stat.shift_done) state_in = S_OUT;
         end
         S_RETIRE: begin
            if (stat.scan_done) state_in = S_OUT;
            else cmd.op = DP_RETIRE;
         end
         S_FULL: begin cmd.op = DP_FULL; state_in = S_OUT; end
         S_OUT: begin out_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end
endmodule

// File: src/staging_region_allocator.sv
// top level of the staging region allocator
// Allocator over an offset-sorted table of up to MAX_REGIONS staging regions. Each word is
// handled alone through a sequencer that walks the table one entry per cycle: an allocate
// merges ready neighbors (one pass), searches first fit, else takes the largest ready region
// or restarts the table, and erases the grant by shifting the tail down (one pass together),
// then inserts any remainder by a position search and a shift up (one pass together); a
// commit inserts alike and a retire readies the regions of its tag in one pass. The response
// is held in a register until taken, and the next word is accepted the cycle after. A buffer
// size write reinitialises the table and blocks input, but only if the sequencer is idle.
module staging_region_allocator import sra_pkg::*; #(
   parameter int MAX_REGIONS = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   sra_req_if.sink     req,
   sra_rsp_if.source   rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   logic [31:0] buf_ff;
   logic [3:0]  al_ff;
   logic [1:0]  op_ff;
   logic [31:0] sz_ff, of_ff;
   logic [15:0] tg_ff;
   sra_cmd_type cmd;
   sra_status_type stat;
   logic cfg_init;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= BUFFER_SIZE_RESET;
         al_ff <= ALIGN_LOG2_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_BUFFER_SIZE) buf_ff <= csr_data;
         else al_ff <= csr_data[3:0];
      end
   end

   // init pulse follows a buffer size write
   always_ff @(posedge clock) begin
      if (reset) cfg_init <= 1'b0;
      else cfg_init <= csr_write && csr_index == CSR_BUFFER_SIZE;
   end

   // request word capture
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff <= req.opcode; sz_ff <= req.req_size;
         of_ff <= req.region_offset; tg_ff <= req.tag;
      end
   end

   sra_ctrl u_ctrl (
      .clock, .reset, .in_valid(req.valid), .in_op(op_ff), .cfg_init, .stat,
      .in_ready(req.ready), .out_valid(rsp.valid), .out_ready(rsp.ready), .cmd
   );

   sra_datapath #(.MAX_REGIONS(MAX_REGIONS), .TAG_BITS(TAG_BITS)) u_dp (
      .clock, .reset, .cmd,
      .in_op(cmd.op == DP_LOAD ? req.opcode : op_ff),
      .in_size(cmd.op == DP_LOAD ? req.req_size : sz_ff),
      .in_off(cmd.op == DP_LOAD ? req.region_offset : of_ff),
      .in_tag(cmd.op == DP_LOAD ? req.tag : tg_ff),
      .buffer_size(buf_ff), .align_log2(al_ff), .stat,
      .grant_offset(rsp.grant_offset), .grant_size(rsp.grant_size),
      .waited(rsp.waited), .status(rsp.status)
   );
endmodule

// File: src/sra_checker.sv
// port-level checks for the staging region allocator
module sra_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [31:0] grant_size,
   input logic [31:0] grant_offset
);
   // no new word while a response is pending
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept with pending response");
   // no response straight after an accepted word
   a_resp_after: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("response too early");
   // held response keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(grant_size)
         && $stable(grant_offset))) else $error("response changed");
endmodule

bind staging_region_allocator sra_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .grant_size(rsp.grant_size), .grant_offset(rsp.grant_offset)
);
